/* hw/rtl/gcd_pkg.sv */
package gcd_pkg;

   // Field widths
   localparam int LAT_W    = 31;
   localparam int LON_W    = 32;
   localparam int RADIUS_W = 23;
   localparam int DIST_W   = 33;

   // Pipeline shape
   localparam int CORDIC_STEPS_DEF = 32;
   localparam int STEP_LIMIT       = 62;
   localparam int SQRT_STEPS       = 64;
   localparam int LANES            = 4;

   // Angle constants, degrees * 2^23
   localparam logic signed [33:0] QUARTER_Q23 = 34'sd754974720;
   localparam logic signed [33:0] HALF_Q23    = 34'sd1509949440;
   localparam logic signed [33:0] FULL_Q23    = 34'sd3019898880;

   localparam logic [63:0]        PI_Q62       = 64'hC90FDAA22168C235;
   localparam logic [63:0]        DEG2RAD_Q64  = PI_Q62 / 64'd45;
   localparam logic signed [63:0] GAIN_INV_Q62 = 64'sd2800459870029452954;
   localparam logic [127:0]       ONE_Q124     = 128'd1 << 124;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6378137;
   localparam logic [DIST_W-1:0]   DIST_MAX     = '1;

   // atan(2^-idx) in Q61: pi/4 for the first step, else the alternating series
   function automatic logic signed [63:0] atan_entry(input int unsigned idx);
      logic signed [63:0] sum;
      logic [63:0]        num;
      logic [63:0]        quo;
      logic [63:0]        rem;
      int unsigned        e;
      int unsigned        den;
      sum = '0;
      if (idx == 0) begin
         sum = signed'((PI_Q62 + 64'd4) >> 3);
      end else begin
         for (int unsigned k = 0; k < 62; k++) begin
            e = idx * (2 * k + 1);
            if (e <= 61) begin
               num = 64'd1 << (61 - e);
               den = 2 * k + 1;
               rem = '0;
               quo = '0;
               // long division, one quotient bit at a time
               for (int b = 63; b >= 0; b--) begin
                  rem = {rem[62:0], num[b]};
                  if (rem >= 64'(den)) begin
                     rem    = rem - 64'(den);
                     quo[b] = 1'b1;
                  end
               end
               if (k[0]) sum = sum - signed'(quo);
               else sum = sum + signed'(quo);
            end
         end
      end
      return sum;
   endfunction

endpackage

/* hw/rtl/gcd_cordic.sv */
module gcd_cordic #(
   parameter int STEPS     = gcd_pkg::CORDIC_STEPS_DEF,
   parameter bit VECTORING = 1'b0
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] x_start,
   input  logic signed [63:0] y_start,
   input  logic signed [63:0] z_start,
   output logic signed [63:0] x_end,
   output logic signed [63:0] y_end,
   output logic signed [63:0] z_end
);
   import gcd_pkg::*;

   logic signed [63:0] x_ff [STEPS];
   logic signed [63:0] y_ff [STEPS];
   logic signed [63:0] z_ff [STEPS];
   logic signed [63:0] x_in [STEPS];
   logic signed [63:0] y_in [STEPS];
   logic signed [63:0] z_in [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [63:0] ANGLE = atan_entry(i);
      logic signed [63:0] xp;
      logic signed [63:0] yp;
      logic signed [63:0] zp;
      logic               up;

      if (i == 0) begin : g_first
         assign xp = x_start;
         assign yp = y_start;
         assign zp = z_start;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
      end

      // rotate: steer z to zero; vectoring: steer y to zero
      assign up      = VECTORING ? yp[63] : !zp[63];
      assign x_in[i] = up ? xp - (yp >>> i) : xp + (yp >>> i);
      assign y_in[i] = up ? yp + (xp >>> i) : yp - (xp >>> i);
      assign z_in[i] = up ? zp - ANGLE : zp + ANGLE;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_end = x_ff[STEPS-1];
   assign y_end = y_ff[STEPS-1];
   assign z_end = z_ff[STEPS-1];

endmodule

/* hw/rtl/great_circle_distance_core.sv */
// Haversine distance between two points given in degrees * 2^23, result in meters * 256.
// Fully pipelined: one request is taken every cycle while the output is not stalled.
// The depth is set by two CORDIC chains (four parallel rotation units for the sines and
// cosines, one vectoring unit for the arctangent), each one stage per step, and by two
// 64-stage square root chains. The whole pipeline holds when a response waits under
// rsp_stall; an empty output register lets requests keep flowing. The sphere radius
// (csr_wr_data) is sampled at the final multiply, so write it only while no request is
// in flight.
module great_circle_distance_core #(
   parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [gcd_pkg::LAT_W-1:0]    req_first_latitude,
   input  logic signed [gcd_pkg::LON_W-1:0]    req_first_longitude,
   input  logic signed [gcd_pkg::LAT_W-1:0]    req_second_latitude,
   input  logic signed [gcd_pkg::LON_W-1:0]    req_second_longitude,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [gcd_pkg::DIST_W-1:0]   rsp_distance_scaled,
   input  logic                                csr_wr_en,
   input  logic        [gcd_pkg::RADIUS_W-1:0] csr_wr_data
);
   import gcd_pkg::*;

   localparam int STEPS = (CORDIC_STEPS < STEP_LIMIT) ? CORDIC_STEPS : STEP_LIMIT;
   localparam int DEPTH = 2 * STEPS + SQRT_STEPS + 21;
   localparam logic [94:0] RND_RAD  = 95'd1 << 26;
   localparam logic [86:0] RND_DIST = 87'd1 << 51;

   function automatic logic signed [31:0] wrap_turn(input logic signed [33:0] d);
      logic signed [33:0] r;
      if (d >= HALF_Q23) r = d - FULL_Q23;
      else if (d < -HALF_Q23) r = d + FULL_Q23;
      else r = d;
      return r[31:0];
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   logic                en;
   logic [DEPTH-1:0]    valid_ff;
   logic                rsp_valid_ff;
   logic [DIST_W-1:0]   dist_ff;
   logic [DIST_W-1:0]   dist_in;
   logic [RADIUS_W-1:0] radius_ff;

   // stage 1: capture and differences
   logic signed [LAT_W-1:0] lat1_ff, lat2_ff;
   logic signed [LAT_W:0]   dlat_ff, dlat_in;
   logic signed [LON_W:0]   dlon_ff, dlon_in;

   // stages 2..6: angle reduction and degrees to radians, one lane per CORDIC
   logic signed [31:0] w2_ff   [LANES];
   logic signed [31:0] w2_in   [LANES];
   logic [30:0]        mag3_ff [LANES];
   logic [30:0]        mag3_in [LANES];
   logic               neg3_ff [LANES];
   logic               neg3_in [LANES];
   logic [1:0]         flip3_ff, flip3_in;
   logic [62:0]        pl4_ff  [LANES];
   logic [62:0]        pl4_in  [LANES];
   logic [62:0]        ph4_ff  [LANES];
   logic [62:0]        ph4_in  [LANES];
   logic               neg4_ff [LANES];
   logic [63:0]        r5_ff   [LANES];
   logic [63:0]        r5_in   [LANES];
   logic               neg5_ff [LANES];
   logic signed [63:0] z6_ff   [LANES];
   logic signed [63:0] z6_in   [LANES];
   logic signed [63:0] rot_x   [LANES];
   logic signed [63:0] rot_y   [LANES];
   logic [STEPS+2:0][1:0] fl_ff;

   // sine magnitudes, cosine magnitudes and product sign
   logic [63:0] g_s1_ff, g_s2_ff, g_m1_ff, g_m2_ff;
   logic        g_neg_ff, g_neg_in;

   // 64x64 multiplier lanes, three stages each
   logic [63:0]  mul_a   [LANES];
   logic [63:0]  mul_b   [LANES];
   logic [63:0]  mll_ff  [LANES];
   logic [63:0]  mll_in  [LANES];
   logic [63:0]  mlh_ff  [LANES];
   logic [63:0]  mlh_in  [LANES];
   logic [63:0]  mhl_ff  [LANES];
   logic [63:0]  mhl_in  [LANES];
   logic [63:0]  mhh_ff  [LANES];
   logic [63:0]  mhh_in  [LANES];
   logic [127:0] mcat_ff [LANES];
   logic [127:0] mcat_in [LANES];
   logic [64:0]  mmid_ff [LANES];
   logic [64:0]  mmid_in [LANES];
   logic [127:0] mp_ff   [LANES];
   logic [127:0] mp_in   [LANES];
   logic [5:0][63:0]  s2d_ff;
   logic [5:0][127:0] t1d_ff;
   logic [8:0]        ngd_ff;

   // a, clamp and 1 - a
   logic [127:0] a_ff, a_in;
   logic [127:0] sq_start_ff [2];
   logic [127:0] sq_start_in [2];

   // square root chains
   logic [65:0]  sq_rem_ff  [2][SQRT_STEPS];
   logic [65:0]  sq_rem_in  [2][SQRT_STEPS];
   logic [63:0]  sq_root_ff [2][SQRT_STEPS];
   logic [63:0]  sq_root_in [2][SQRT_STEPS];
   logic [127:0] sq_num_ff  [2][SQRT_STEPS];
   logic [127:0] sq_num_in  [2][SQRT_STEPS];

   // arctangent and final scaling
   logic signed [63:0] vec_z;
   logic [62:0]        zc_ff, zc_in;
   logic [54:0]        fpl_ff, fpl_in;
   logic [53:0]        fph_ff, fph_in;
   logic [86:0]        fp_ff, fp_in;

   // hold everything while a response waits
   assign en                  = !rsp_valid_ff || !rsp_stall;
   assign req_stall           = !en;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_distance_scaled = dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= RADIUS_RESET;
      end else begin
         if (en) begin
            valid_ff     <= {valid_ff[DEPTH-2:0], req_valid};
            rsp_valid_ff <= valid_ff[DEPTH-1];
         end
         if (csr_wr_en) radius_ff <= csr_wr_data;
      end
   end

   assign dlat_in = (LAT_W+1)'(req_second_latitude) - (LAT_W+1)'(req_first_latitude);
   assign dlon_in = (LON_W+1)'(req_second_longitude) - (LON_W+1)'(req_first_longitude);

   always_comb begin
      w2_in[0] = wrap_turn(34'(dlat_ff));
      w2_in[1] = wrap_turn(34'(dlon_ff));
      w2_in[2] = lat1_ff[LAT_W-1] ? -32'(lat1_ff) : 32'(lat1_ff);
      w2_in[3] = lat2_ff[LAT_W-1] ? -32'(lat2_ff) : 32'(lat2_ff);
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [94:0] sum5;

      if (l < 2) begin : g_sin
         // half angle: degrees * 2^23 read as degrees * 2^24
         assign neg3_in[l] = w2_ff[l][31];
         assign mag3_in[l] = 31'(w2_ff[l][31] ? -w2_ff[l] : w2_ff[l]);
      end else begin : g_cos
         logic               flip;
         logic signed [31:0] m;
         // beyond 90 degrees fold back and negate the cosine later
         assign flip           = 34'(w2_ff[l]) > QUARTER_Q23;
         assign m              = flip ? 32'(HALF_Q23) - w2_ff[l] : w2_ff[l];
         assign flip3_in[l-2]  = flip;
         assign neg3_in[l]     = 1'b0;
         assign mag3_in[l]     = {m[29:0], 1'b0};
      end

      assign pl4_in[l] = 63'(mag3_ff[l]) * 63'(DEG2RAD_Q64[31:0]);
      assign ph4_in[l] = 63'(mag3_ff[l]) * 63'(DEG2RAD_Q64[63:32]);
      assign sum5      = {ph4_ff[l], 32'd0} + 95'(pl4_ff[l]) + RND_RAD;
      assign r5_in[l]  = sum5[90:27];
      assign z6_in[l]  = neg5_ff[l] ? -signed'(r5_ff[l]) : signed'(r5_ff[l]);

      gcd_cordic #(
         .STEPS     (STEPS),
         .VECTORING (1'b0)
      ) u_rot (
         .clock,
         .en,
         .x_start (GAIN_INV_Q62),
         .y_start (64'sd0),
         .z_start (z6_ff[l]),
         .x_end   (rot_x[l]),
         .y_end   (rot_y[l]),
         .z_end   ()
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lat1_ff  <= req_first_latitude;
         lat2_ff  <= req_second_latitude;
         dlat_ff  <= dlat_in;
         dlon_ff  <= dlon_in;
         w2_ff    <= w2_in;
         mag3_ff  <= mag3_in;
         neg3_ff  <= neg3_in;
         flip3_ff <= flip3_in;
         pl4_ff   <= pl4_in;
         ph4_ff   <= ph4_in;
         neg4_ff  <= neg3_ff;
         r5_ff    <= r5_in;
         neg5_ff  <= neg4_ff;
         z6_ff    <= z6_in;
         fl_ff    <= {fl_ff[STEPS+1:0], flip3_ff};
      end
   end

   // cosine sign: folded angle flips it, an exact zero stays positive
   assign g_neg_in = ((rot_x[2] != '0) && (rot_x[2][63] ^ fl_ff[STEPS+2][0]))
                   ^ ((rot_x[3] != '0) && (rot_x[3][63] ^ fl_ff[STEPS+2][1]));

   always_ff @(posedge clock) begin
      if (en) begin
         g_s1_ff  <= mag64(rot_y[0]);
         g_s2_ff  <= mag64(rot_y[1]);
         g_m1_ff  <= mag64(rot_x[2]);
         g_m2_ff  <= mag64(rot_x[3]);
         g_neg_ff <= g_neg_in;
      end
   end

   // cos*cos, sin^2(dLat/2), (cos*cos)*sin(dLon/2), then that times sin(dLon/2)
   always_comb begin
      mul_a[0] = g_m1_ff;
      mul_b[0] = g_m2_ff;
      mul_a[1] = g_s1_ff;
      mul_b[1] = g_s1_ff;
      mul_a[2] = mp_ff[0][125:62];
      mul_b[2] = s2d_ff[2];
      mul_a[3] = mp_ff[2][125:62];
      mul_b[3] = s2d_ff[5];
   end

   for (genvar l = 0; l < LANES; l++) begin : g_mul
      assign mll_in[l]  = 64'(mul_a[l][31:0]) * 64'(mul_b[l][31:0]);
      assign mlh_in[l]  = 64'(mul_a[l][31:0]) * 64'(mul_b[l][63:32]);
      assign mhl_in[l]  = 64'(mul_a[l][63:32]) * 64'(mul_b[l][31:0]);
      assign mhh_in[l]  = 64'(mul_a[l][63:32]) * 64'(mul_b[l][63:32]);
      assign mcat_in[l] = {mhh_ff[l], mll_ff[l]};
      assign mmid_in[l] = 65'(mlh_ff[l]) + 65'(mhl_ff[l]);
      assign mp_in[l]   = mcat_ff[l] + {31'd0, mmid_ff[l], 32'd0};
   end

   always_comb begin
      if (ngd_ff[8]) a_in = (t1d_ff[5] >= mp_ff[3]) ? t1d_ff[5] - mp_ff[3] : '0;
      else a_in = t1d_ff[5] + mp_ff[3];
      // clamp a to one
      sq_start_in[0] = (a_ff > ONE_Q124) ? ONE_Q124 : a_ff;
      sq_start_in[1] = (a_ff > ONE_Q124) ? '0 : ONE_Q124 - a_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mll_in_hold: begin
            mll_ff <= mll_in;
            mlh_ff <= mlh_in;
            mhl_ff <= mhl_in;
            mhh_ff <= mhh_in;
         end
         mcat_ff     <= mcat_in;
         mmid_ff     <= mmid_in;
         mp_ff       <= mp_in;
         s2d_ff      <= {s2d_ff[4:0], g_s2_ff};
         t1d_ff      <= {t1d_ff[4:0], mp_ff[1]};
         ngd_ff      <= {ngd_ff[7:0], g_neg_ff};
         a_ff        <= a_in;
         sq_start_ff <= sq_start_in;
      end
   end

   // restoring square root, one result bit per stage
   for (genvar l = 0; l < 2; l++) begin : g_sq_lane
      for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sq_step
         logic [65:0]  rem_p;
         logic [63:0]  root_p;
         logic [127:0] num_p;
         logic [67:0]  rem_sh;
         logic [67:0]  trial;
         logic         take;

         if (j == 0) begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign num_p  = sq_start_ff[l];
         end else begin : g_next
            assign rem_p  = sq_rem_ff[l][j-1];
            assign root_p = sq_root_ff[l][j-1];
            assign num_p  = sq_num_ff[l][j-1];
         end

         assign rem_sh = {rem_p, num_p[127:126]};
         assign trial  = {2'b00, root_p, 2'b01};
         assign take   = rem_sh >= trial;
         assign sq_rem_in[l][j]  = take ? 66'(rem_sh - trial) : rem_sh[65:0];
         assign sq_root_in[l][j] = {root_p[62:0], take};
         assign sq_num_in[l][j]  = {num_p[125:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
         sq_num_ff  <= sq_num_in;
      end
   end

   gcd_cordic #(
      .STEPS     (STEPS),
      .VECTORING (1'b1)
   ) u_vec (
      .clock,
      .en,
      .x_start (signed'(sq_root_ff[1][SQRT_STEPS-1])),
      .y_start (signed'(sq_root_ff[0][SQRT_STEPS-1])),
      .z_start (64'sd0),
      .x_end   (),
      .y_end   (),
      .z_end   (vec_z)
   );

   // drop a negative angle, scale by radius, round and saturate
   assign zc_in   = vec_z[63] ? '0 : vec_z[62:0];
   assign fpl_in  = 55'(radius_ff) * 55'(zc_ff[31:0]);
   assign fph_in  = 54'(radius_ff) * 54'(zc_ff[62:32]);
   assign fp_in   = 87'({fph_ff, 32'd0}) + 87'(fpl_ff) + RND_DIST;
   assign dist_in = (fp_ff[86:85] != 2'b00) ? DIST_MAX : fp_ff[84:52];

   always_ff @(posedge clock) begin
      if (en) begin
         zc_ff   <= zc_in;
         fpl_ff  <= fpl_in;
         fph_ff  <= fph_in;
         fp_ff   <= fp_in;
         dist_ff <= dist_in;
      end
   end

endmodule
